[rtl/core/drop_oldest_ring_buffer_defines.svh]
// Assertion macros for the ring buffer checker.
// Every property is sampled on the rising clock edge and is disabled while reset is low.
`ifndef DROP_OLDEST_RING_BUFFER_DEFINES_SVH
`define DROP_OLDEST_RING_BUFFER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DORB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring buffer check failed");

// Consequent must hold in the cycle after the antecedent
`define DORB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring buffer check failed");

`endif

[rtl/core/dorb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dorb_pkg;

    // Widths of the fixed fields
    localparam int TS_W     = 32;
    localparam int CNT_W    = 32;
    localparam int SAMPLE_W = 64;

    // Operation codes
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_TAKE  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

endpackage

`default_nettype wire

[rtl/core/dorb_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module dorb_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write one slot, read one slot into the data register
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

[rtl/core/drop_oldest_ring_buffer.sv]
`timescale 1ns / 1ps
`default_nettype none
// A transaction accepted into the input register moves into the ring state and the
// output register once the output register is free or drained, and out_valid then rises.
// Throughput: one transaction per cycle, set by a single-step ring update and a slot
// memory with a write port and a registered read port; the input stalls only while a
// result waits for out_ready.
// Reset: rst_n clears pointers, counters and valid flags; slot contents stay undefined.

module drop_oldest_ring_buffer #(
    parameter int CAPACITY   = 16,
    parameter int VALUE_BITS = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [1:0]                    op,
    input  wire logic [dorb_pkg::TS_W-1:0]     time_stamp,
    input  wire logic [dorb_pkg::SAMPLE_W-1:0] sample_value,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic                               pop_valid,
    output logic      [dorb_pkg::TS_W-1:0]     out_time,
    output logic      [dorb_pkg::CNT_W-1:0]    out_seq,
    output logic      [dorb_pkg::SAMPLE_W-1:0] out_value,
    output logic      [dorb_pkg::CNT_W-1:0]    fill_level,
    output logic      [dorb_pkg::CNT_W-1:0]    drops_taken,
    output logic      [dorb_pkg::CNT_W-1:0]    drops_total,
    output logic      [dorb_pkg::CNT_W-1:0]    next_seq
);

    localparam int CW      = dorb_pkg::CNT_W;
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int KEEP    = CAPACITY - 1;
    localparam int ENTRY_W = dorb_pkg::TS_W + CW + VALUE_BITS;
    // Slot of counter 2^32, i.e. where the slot mapping lands after the counter wraps
    localparam logic [63:0] TWO_POW_32 = 64'd1 << 32;
    localparam logic [63:0] WRAP_SLOT  = TWO_POW_32 % 64'(CAPACITY);

    // Input stage
    logic                  s1_valid_reg;
    dorb_pkg::op_t         s1_op_reg;
    logic [dorb_pkg::TS_W-1:0] s1_time_reg;
    logic [VALUE_BITS-1:0] s1_value_reg;

    // Ring state
    logic [CW-1:0]    head_reg, head_next;
    logic [CW-1:0]    tail_reg, tail_next;
    logic [CW-1:0]    fill_reg, fill_next;
    logic [IDX_W-1:0] head_slot_reg, head_slot_next;
    logic [IDX_W-1:0] tail_slot_reg, tail_slot_next;
    logic [CW-1:0]    seq_reg, seq_next;
    logic [CW-1:0]    recent_reg, recent_next;
    logic [CW-1:0]    total_reg, total_next;

    // Output stage
    logic          out_valid_reg;
    logic          pop_valid_reg, pop_valid_next;
    logic [CW-1:0] taken_reg, taken_next;

    // Memory port signals
    logic               wr_en;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_slot;
    logic [ENTRY_W-1:0] wr_entry;
    logic [ENTRY_W-1:0] rd_entry;

    // Pop helpers
    logic             advance;
    logic             over;
    logic [CW-1:0]    gap;
    logic [IDX_W:0]   wrap_sum;
    logic [IDX_W-1:0] jump_slot;
    logic             rd_is_max;

    function automatic logic [IDX_W-1:0] slot_inc(input logic [IDX_W-1:0] s);
        if (s == IDX_W'(CAPACITY - 1))
        begin
            return '0;
        end
        return s + 1'b1;
    endfunction

    // Handshake: the input stage moves on when the output register is free or drained
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;

    // Overflow: keep only the newest CAPACITY-1 entries
    assign over = fill_reg > CW'(KEEP);
    assign gap  = fill_reg - CW'(KEEP);

    // Slot of tail-(CAPACITY-1); when that difference wraps below zero, offset by the wrap slot
    assign wrap_sum = IDX_W'(0) + (IDX_W + 1)'(WRAP_SLOT)
                      + {1'b0, tail_reg[IDX_W-1:0]} + (IDX_W + 1)'(1);
    always_comb
    begin
        if (tail_reg < CW'(KEEP))
        begin
            if (wrap_sum >= (IDX_W + 1)'(CAPACITY))
            begin
                jump_slot = IDX_W'(wrap_sum - (IDX_W + 1)'(CAPACITY));
            end
            else
            begin
                jump_slot = wrap_sum[IDX_W-1:0];
            end
        end
        else
        begin
            jump_slot = slot_inc(tail_slot_reg);
        end
    end

    assign rd_slot   = over ? jump_slot : head_slot_reg;
    assign rd_is_max = over ? (tail_reg == CW'(KEEP - 1)) : (head_reg == '1);
    assign wr_entry  = {s1_time_reg, seq_reg, s1_value_reg};

    // Next state for the transaction in the input stage
    always_comb
    begin
        head_next      = head_reg;
        tail_next      = tail_reg;
        fill_next      = fill_reg;
        head_slot_next = head_slot_reg;
        tail_slot_next = tail_slot_reg;
        seq_next       = seq_reg;
        recent_next    = recent_reg;
        total_next     = total_reg;
        pop_valid_next = 1'b0;
        taken_next     = '0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        unique case (s1_op_reg)
            dorb_pkg::OP_PUSH:
            begin
                wr_en          = advance;
                tail_next      = tail_reg + 1'b1;
                fill_next      = fill_reg + 1'b1;
                seq_next       = seq_reg + 1'b1;
                tail_slot_next = (tail_reg == '1) ? '0 : slot_inc(tail_slot_reg);
            end
            dorb_pkg::OP_POP:
            begin
                if (fill_reg != '0)
                begin
                    rd_en          = advance;
                    pop_valid_next = 1'b1;
                    head_slot_next = rd_is_max ? '0 : slot_inc(rd_slot);
                    if (over)
                    begin
                        head_next   = tail_reg - CW'(KEEP - 1);
                        fill_next   = CW'(KEEP - 1);
                        recent_next = recent_reg + gap;
                        total_next  = total_reg + gap;
                    end
                    else
                    begin
                        head_next = head_reg + 1'b1;
                        fill_next = fill_reg - 1'b1;
                    end
                end
            end
            dorb_pkg::OP_TAKE:
            begin
                taken_next  = recent_reg;
                recent_next = '0;
            end
            dorb_pkg::OP_CLEAR:
            begin
                head_next      = '0;
                tail_next      = '0;
                fill_next      = '0;
                head_slot_next = '0;
                tail_slot_next = '0;
            end
        endcase
    end

    // Hold the accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_op_reg    <= dorb_pkg::op_t'(op);
            s1_time_reg  <= time_stamp;
            s1_value_reg <= sample_value[VALUE_BITS-1:0];
        end
    end

    // Advance ring state and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            head_slot_reg <= '0;
            tail_slot_reg <= '0;
            seq_reg       <= '0;
            recent_reg    <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
            taken_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                head_reg      <= head_next;
                tail_reg      <= tail_next;
                fill_reg      <= fill_next;
                head_slot_reg <= head_slot_next;
                tail_slot_reg <= tail_slot_next;
                seq_reg       <= seq_next;
                recent_reg    <= recent_next;
                total_reg     <= total_next;
                pop_valid_reg <= pop_valid_next;
                taken_reg     <= taken_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    dorb_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (tail_slot_reg),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (rd_slot),
        .rd_data (rd_entry)
    );

    // Drive result fields; the counters after the transaction are the updated state
    assign out_valid   = out_valid_reg;
    assign pop_valid   = pop_valid_reg;
    assign out_time    = pop_valid_reg ? rd_entry[ENTRY_W-1 -: dorb_pkg::TS_W] : '0;
    assign out_seq     = pop_valid_reg ? rd_entry[VALUE_BITS +: CW] : '0;
    assign out_value   = pop_valid_reg
                         ? dorb_pkg::SAMPLE_W'(rd_entry[VALUE_BITS-1:0]) : '0;
    assign fill_level  = fill_reg;
    assign drops_taken = taken_reg;
    assign drops_total = total_reg;
    assign next_seq    = seq_reg;

endmodule

`default_nettype wire

[rtl/core/dorb_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "drop_oldest_ring_buffer_defines.svh"

module dorb_checker #(
    parameter int CAPACITY = 16
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic                          pop_valid,
    input wire logic [dorb_pkg::TS_W-1:0]     out_time,
    input wire logic [dorb_pkg::CNT_W-1:0]    out_seq,
    input wire logic [dorb_pkg::SAMPLE_W-1:0] out_value,
    input wire logic [dorb_pkg::CNT_W-1:0]    fill_level,
    input wire logic [dorb_pkg::CNT_W-1:0]    drops_taken,
    input wire logic [dorb_pkg::CNT_W-1:0]    drops_total,
    input wire logic [dorb_pkg::CNT_W-1:0]    next_seq
);

    // Hold a stalled result
    `DORB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_seq) && $stable(out_value) && $stable(fill_level) && $stable(drops_total))

    // Zero sample fields when no sample was returned
    `DORB_ASSERT_SAME(a_empty_zero, clk, rst_n, out_valid && !pop_valid, out_time == '0 && out_seq == '0 && out_value == '0)

    // A successful pop leaves at most CAPACITY-2 entries pending
    `DORB_ASSERT_SAME(a_pop_fill, clk, rst_n, out_valid && pop_valid, fill_level <= dorb_pkg::CNT_W'(CAPACITY - 2))

    // Only a take transaction reports a drop count, and then never a sample
    `DORB_ASSERT_SAME(a_take_excl, clk, rst_n, out_valid && drops_taken != '0, !pop_valid)

    // A sample is never popped while next_seq and drops_total are both zero
    `DORB_ASSERT_SAME(a_seq_issued, clk, rst_n, out_valid && pop_valid && next_seq == '0 && drops_total == '0, 1'b0)

endmodule

bind drop_oldest_ring_buffer dorb_checker #(.CAPACITY(CAPACITY)) u_dorb_checker (.*);

`default_nettype wire
